/* hw/rtl/knxtc_pkg.sv */
// knxtc_pkg: shared constants for the knx telegram checker
// telegram layout, checksum seed and application service codes
// no dependencies
package knxtc_pkg;

    // telegram layout
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned HDR_DEPTH    = 8;
    localparam logic [7:0]  XOR_SEED     = 8'hFF;

    // decoded application service
    localparam logic [4:0] SVC_UNKNOWN        = 5'd0;
    localparam logic [4:0] SVC_GROUP_READ     = 5'd1;
    localparam logic [4:0] SVC_GROUP_RESP     = 5'd2;
    localparam logic [4:0] SVC_GROUP_WRITE    = 5'd3;
    localparam logic [4:0] SVC_PHYS_WRITE     = 5'd4;
    localparam logic [4:0] SVC_PHYS_READ      = 5'd5;
    localparam logic [4:0] SVC_PHYS_RESP      = 5'd6;
    localparam logic [4:0] SVC_PROP_READ      = 5'd7;
    localparam logic [4:0] SVC_PROP_RESP      = 5'd8;
    localparam logic [4:0] SVC_PROP_WRITE     = 5'd9;
    localparam logic [4:0] SVC_AUTH_REQ       = 5'd10;
    localparam logic [4:0] SVC_AUTH_RESP      = 5'd11;
    localparam logic [4:0] SVC_MEM_READ       = 5'd12;
    localparam logic [4:0] SVC_MEM_RESP       = 5'd13;
    localparam logic [4:0] SVC_MEM_WRITE      = 5'd14;
    localparam logic [4:0] SVC_DESC_READ      = 5'd15;
    localparam logic [4:0] SVC_DESC_RESP      = 5'd16;
    localparam logic [4:0] SVC_RESTART        = 5'd17;

    // 4-bit apci codes
    localparam logic [3:0] APCI4_GROUP_READ   = 4'h0;
    localparam logic [3:0] APCI4_GROUP_RESP   = 4'h1;
    localparam logic [3:0] APCI4_GROUP_WRITE  = 4'h2;
    localparam logic [3:0] APCI4_PHYS_WRITE   = 4'h3;
    localparam logic [3:0] APCI4_PHYS_READ    = 4'h4;
    localparam logic [3:0] APCI4_PHYS_RESP    = 4'h5;
    localparam logic [3:0] APCI4_MEM_READ     = 4'h8;
    localparam logic [3:0] APCI4_MEM_RESP     = 4'h9;
    localparam logic [3:0] APCI4_MEM_WRITE    = 4'hA;
    localparam logic [3:0] APCI4_DESC_READ    = 4'hC;
    localparam logic [3:0] APCI4_DESC_RESP    = 4'hD;
    localparam logic [3:0] APCI4_RESTART      = 4'hE;
    localparam logic [3:0] APCI4_EXTENDED     = 4'hF;

    // 6-bit extended codes
    localparam logic [5:0] APCI6_PROP_READ    = 6'h15;
    localparam logic [5:0] APCI6_PROP_RESP    = 6'h16;
    localparam logic [5:0] APCI6_PROP_WRITE   = 6'h17;
    localparam logic [5:0] APCI6_AUTH_REQ     = 6'h11;
    localparam logic [5:0] APCI6_AUTH_RESP    = 6'h12;

endpackage

/* hw/rtl/knx_telegram_checker_unit.sv */
// knx_telegram_checker_unit: byte-wise knx tp1 telegram parser and checker
// depends on knxtc_pkg
// a result is registered and appears in the cycle after its checksum word is accepted
// throughput: one word per cycle; the single output register holds a result
// and the input stalls only while that register is full and not taken
// reset: synchronous active-low i_rst_n clears frame state and output valid, not header bytes
module knx_telegram_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_checksum_ok,
    output logic        o_repeated,
    output logic [1:0]  o_priority_res,
    output logic [15:0] o_source_address,
    output logic [15:0] o_target_address,
    output logic        o_target_is_group,
    output logic        o_is_broadcast,
    output logic [2:0]  o_routing_count,
    output logic [4:0]  o_payload_bytes,
    output logic [4:0]  o_service,
    output logic [1:0]  o_transport_type,
    output logic [3:0]  o_sequence_number
);
    import knxtc_pkg::*;

    // frame state
    logic [4:0] r_count;
    logic [7:0] r_xor;
    logic       r_in_frame;
    logic [7:0] r_hdr [HDR_DEPTH];

    // output register
    logic        r_out_valid;
    logic        r_checksum_ok;
    logic        r_repeated;
    logic [1:0]  r_priority_res;
    logic [15:0] r_source_address;
    logic [15:0] r_target_address;
    logic        r_target_is_group;
    logic        r_is_broadcast;
    logic [2:0]  r_routing_count;
    logic [4:0]  r_payload_bytes;
    logic [4:0]  r_service;
    logic [1:0]  r_transport_type;
    logic [3:0]  r_sequence_number;

    logic       w_accept;
    logic       w_active;
    logic [4:0] w_idx;
    logic [7:0] w_xor;
    logic [4:0] w_len;
    logic       w_last;
    logic [7:0] w_b7;
    logic [3:0] w_code4;
    logic [5:0] w_code6;
    logic [4:0] w_service;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // effective frame position, a start flag restarts parsing
    assign w_active = i_frame_start || r_in_frame;
    assign w_idx    = i_frame_start ? 5'd0 : r_count;
    assign w_xor    = i_frame_start ? XOR_SEED : r_xor;

    // checksum position; header byte 5 is always stored by then
    assign w_len  = {1'b0, r_hdr[5][3:0]} + 5'd1;
    assign w_last = w_active && (w_idx > 5'(HEADER_BYTES))
                    && (w_idx == 5'(HEADER_BYTES) + w_len);

    // with a one-byte payload byte 7 is the current word
    assign w_b7    = (w_idx == 5'(HDR_DEPTH - 1)) ? i_rx_byte : r_hdr[7];
    assign w_code4 = {r_hdr[6][1:0], w_b7[7:6]};
    assign w_code6 = w_b7[5:0];

    // application service decode
    always_comb begin
        case (w_code4)
            APCI4_GROUP_READ:  w_service = SVC_GROUP_READ;
            APCI4_GROUP_RESP:  w_service = SVC_GROUP_RESP;
            APCI4_GROUP_WRITE: w_service = SVC_GROUP_WRITE;
            APCI4_PHYS_WRITE:  w_service = (w_code6 == 6'd0) ? SVC_PHYS_WRITE : SVC_UNKNOWN;
            APCI4_PHYS_READ:   w_service = (w_code6 == 6'd0) ? SVC_PHYS_READ : SVC_UNKNOWN;
            APCI4_PHYS_RESP:   w_service = (w_code6 == 6'd0) ? SVC_PHYS_RESP : SVC_UNKNOWN;
            APCI4_MEM_READ:    w_service = (w_code6[5:4] == 2'd0) ? SVC_MEM_READ : SVC_UNKNOWN;
            APCI4_MEM_RESP:    w_service = (w_code6[5:4] == 2'd0) ? SVC_MEM_RESP : SVC_UNKNOWN;
            APCI4_MEM_WRITE:   w_service = (w_code6[5:4] == 2'd0) ? SVC_MEM_WRITE : SVC_UNKNOWN;
            APCI4_DESC_READ:   w_service = (w_code6 == 6'd0) ? SVC_DESC_READ : SVC_UNKNOWN;
            APCI4_DESC_RESP:   w_service = (w_code6 == 6'd0) ? SVC_DESC_RESP : SVC_UNKNOWN;
            APCI4_RESTART:     w_service = (w_code6 == 6'd0) ? SVC_RESTART : SVC_UNKNOWN;
            APCI4_EXTENDED: begin
                case (w_code6)
                    APCI6_PROP_READ:  w_service = SVC_PROP_READ;
                    APCI6_PROP_RESP:  w_service = SVC_PROP_RESP;
                    APCI6_PROP_WRITE: w_service = SVC_PROP_WRITE;
                    APCI6_AUTH_REQ:   w_service = SVC_AUTH_REQ;
                    APCI6_AUTH_RESP:  w_service = SVC_AUTH_RESP;
                    default:          w_service = SVC_UNKNOWN;
                endcase
            end
            default:           w_service = SVC_UNKNOWN;
        endcase
    end

    // frame control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 5'd0;
            r_xor      <= XOR_SEED;
            r_in_frame <= 1'b0;
        end else if (w_accept && w_active) begin
            if (w_last) begin
                r_count    <= 5'd0;
                r_xor      <= XOR_SEED;
                r_in_frame <= 1'b0;
            end else begin
                r_count    <= w_idx + 5'd1;
                r_xor      <= w_xor ^ i_rx_byte;
                r_in_frame <= 1'b1;
            end
        end
    end

    // header byte capture
    always_ff @(posedge i_clk) begin
        if (w_accept && w_active && w_idx < 5'(HDR_DEPTH)) begin
            r_hdr[w_idx[2:0]] <= i_rx_byte;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_checksum_ok     <= (i_rx_byte == w_xor);
            r_repeated        <= !r_hdr[0][5];
            r_priority_res    <= r_hdr[0][3:2];
            r_source_address  <= {r_hdr[1], r_hdr[2]};
            r_target_address  <= {r_hdr[3], r_hdr[4]};
            r_target_is_group <= r_hdr[5][7];
            r_is_broadcast    <= r_hdr[5][7] && (r_hdr[3] == 8'd0) && (r_hdr[4] == 8'd0);
            r_routing_count   <= r_hdr[5][6:4];
            r_payload_bytes   <= w_len;
            r_service         <= w_service;
            r_transport_type  <= r_hdr[6][7:6];
            r_sequence_number <= r_hdr[6][5:2];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_checksum_ok     = r_checksum_ok;
    assign o_repeated        = r_repeated;
    assign o_priority_res    = r_priority_res;
    assign o_source_address  = r_source_address;
    assign o_target_address  = r_target_address;
    assign o_target_is_group = r_target_is_group;
    assign o_is_broadcast    = r_is_broadcast;
    assign o_routing_count   = r_routing_count;
    assign o_payload_bytes   = r_payload_bytes;
    assign o_service         = r_service;
    assign o_transport_type  = r_transport_type;
    assign o_sequence_number = r_sequence_number;

endmodule

/* hw/rtl/knxtc_checker.sv */
// knxtc_checker: port-level assertions for knx_telegram_checker_unit
// depends on knxtc_pkg; bound to knx_telegram_checker_unit below
module knxtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_target_address,
    input logic        o_target_is_group,
    input logic        o_is_broadcast,
    input logic [4:0]  o_payload_bytes,
    input logic [4:0]  o_service
);
    import knxtc_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_service)
            && $stable(o_target_address))
        else $error("result changed while stalled");

    // a new result only follows an accepted word
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without accepted word");

    // length field in range
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_bytes != 5'd0) && (o_payload_bytes <= 5'd16))
        else $error("payload length out of range");

    // broadcast only for group address zero
    a_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_broadcast |-> o_target_is_group
            && (o_target_address == 16'd0))
        else $error("broadcast flag inconsistent");

    // service code within the defined set
    a_svc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_service <= SVC_RESTART)
        else $error("service code out of range");

endmodule

bind knx_telegram_checker_unit knxtc_checker u_knxtc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_target_address  (o_target_address),
    .o_target_is_group (o_target_is_group),
    .o_is_broadcast    (o_is_broadcast),
    .o_payload_bytes   (o_payload_bytes),
    .o_service         (o_service)
);

/* tb/tb_knx_telegram_checker_unit.sv */
`timescale 1ns / 1ps
// tb_knx_telegram_checker_unit: self-checking bench for the knx tp1 telegram checker
// drives byte-wise telegrams, predicts each decoded header and checks it in order
// depends on knxtc_pkg and knx_telegram_checker_unit
module tb_knx_telegram_checker_unit;
    import knxtc_pkg::*;

    // one decoded telegram, as presented on the result ports
    typedef struct packed {
        logic        checksum_ok;
        logic        repeated;
        logic [1:0]  priority_res;
        logic [15:0] source_address;
        logic [15:0] target_address;
        logic        target_is_group;
        logic        is_broadcast;
        logic [2:0]  routing_count;
        logic [4:0]  payload_bytes;
        logic [4:0]  service;
        logic [1:0]  transport_type;
        logic [3:0]  sequence_number;
    } t_telegram;

    // tracks the telegram parser state and holds the decodes still owed
    class t_knx_frame_tracker;
        logic [4:0]  byte_idx;
        logic [7:0]  xor_acc;
        logic [7:0]  hdr [HDR_DEPTH];
        bit          open;
        t_telegram   owed_q[$];
        int unsigned failures;

        function new();
            byte_idx = '0;
            xor_acc  = XOR_SEED;
            open     = 1'b0;
            failures = 0;
            foreach (hdr[i]) hdr[i] = '0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function logic [4:0] service_of(logic [7:0] b6, logic [7:0] b7);
            logic [3:0] c4;
            logic [5:0] c6;
            c4 = {b6[1:0], b7[7:6]};
            c6 = b7[5:0];
            case (c4)
                APCI4_GROUP_READ:  return SVC_GROUP_READ;
                APCI4_GROUP_RESP:  return SVC_GROUP_RESP;
                APCI4_GROUP_WRITE: return SVC_GROUP_WRITE;
                APCI4_PHYS_WRITE:  return (c6 == 6'd0) ? SVC_PHYS_WRITE : SVC_UNKNOWN;
                APCI4_PHYS_READ:   return (c6 == 6'd0) ? SVC_PHYS_READ : SVC_UNKNOWN;
                APCI4_PHYS_RESP:   return (c6 == 6'd0) ? SVC_PHYS_RESP : SVC_UNKNOWN;
                APCI4_EXTENDED: begin
                    case (c6)
                        APCI6_PROP_READ:  return SVC_PROP_READ;
                        APCI6_PROP_RESP:  return SVC_PROP_RESP;
                        APCI6_PROP_WRITE: return SVC_PROP_WRITE;
                        APCI6_AUTH_REQ:   return SVC_AUTH_REQ;
                        APCI6_AUTH_RESP:  return SVC_AUTH_RESP;
                        default:          return SVC_UNKNOWN;
                    endcase
                end
                // memory services carry a 4-bit count in the low bits
                APCI4_MEM_READ:    return (c6[5:4] == 2'b00) ? SVC_MEM_READ : SVC_UNKNOWN;
                APCI4_MEM_RESP:    return (c6[5:4] == 2'b00) ? SVC_MEM_RESP : SVC_UNKNOWN;
                APCI4_MEM_WRITE:   return (c6[5:4] == 2'b00) ? SVC_MEM_WRITE : SVC_UNKNOWN;
                APCI4_DESC_READ:   return (c6 == 6'd0) ? SVC_DESC_READ : SVC_UNKNOWN;
                APCI4_DESC_RESP:   return (c6 == 6'd0) ? SVC_DESC_RESP : SVC_UNKNOWN;
                APCI4_RESTART:     return (c6 == 6'd0) ? SVC_RESTART : SVC_UNKNOWN;
                default:           return SVC_UNKNOWN;
            endcase
        endfunction

        // advance the parser by one accepted word; a checksum word yields a decode
        function void note_word(logic [7:0] b, logic start);
            logic [4:0] len;
            t_telegram  t;
            if (start) begin
                byte_idx = '0;
                xor_acc  = XOR_SEED;
                open     = 1'b1;
            end
            if (!open) return;
            if (byte_idx < HDR_DEPTH) hdr[byte_idx[2:0]] = b;
            len = {1'b0, hdr[5][3:0]} + 5'd1;
            if (byte_idx > HEADER_BYTES && byte_idx == HEADER_BYTES + len) begin
                t.checksum_ok     = (b == xor_acc);
                t.repeated        = ~hdr[0][5];
                t.priority_res    = hdr[0][3:2];
                t.source_address  = {hdr[1], hdr[2]};
                t.target_address  = {hdr[3], hdr[4]};
                t.target_is_group = hdr[5][7];
                t.is_broadcast    = hdr[5][7] && hdr[3] == 8'd0 && hdr[4] == 8'd0;
                t.routing_count   = hdr[5][6:4];
                t.payload_bytes   = len;
                t.service         = service_of(hdr[6], hdr[7]);
                t.transport_type  = hdr[6][7:6];
                t.sequence_number = hdr[6][5:2];
                owed_q.push_back(t);
                open     = 1'b0;
                byte_idx = '0;
                xor_acc  = XOR_SEED;
                return;
            end
            xor_acc  ^= b;
            byte_idx += 5'd1;
        endfunction

        function string diff_fields(t_telegram a, t_telegram b);
            string s;
            s = "";
            if (a.checksum_ok !== b.checksum_ok)         s = {s, " checksum_ok"};
            if (a.repeated !== b.repeated)               s = {s, " repeated"};
            if (a.priority_res !== b.priority_res)       s = {s, " priority_res"};
            if (a.source_address !== b.source_address)   s = {s, " source_address"};
            if (a.target_address !== b.target_address)   s = {s, " target_address"};
            if (a.target_is_group !== b.target_is_group) s = {s, " target_is_group"};
            if (a.is_broadcast !== b.is_broadcast)       s = {s, " is_broadcast"};
            if (a.routing_count !== b.routing_count)     s = {s, " routing_count"};
            if (a.payload_bytes !== b.payload_bytes)     s = {s, " payload_bytes"};
            if (a.service !== b.service)                 s = {s, " service"};
            if (a.transport_type !== b.transport_type)   s = {s, " transport_type"};
            if (a.sequence_number !== b.sequence_number) s = {s, " sequence_number"};
            return s;
        endfunction

        // compare one taken decode with the oldest one owed
        function void check_result(t_telegram got);
            t_telegram want;
            if (owed_q.size() == 0) begin
                flag($sformatf("%0t: decode with none owed: %p", $realtime, got));
                return;
            end
            want = owed_q.pop_front();
            if (got !== want)
                flag($sformatf("%0t: mismatch in%s\n  expected %p\n  actual   %p",
                               $realtime, diff_fields(want, got), want, got));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_checksum_ok;
    logic        o_repeated;
    logic [1:0]  o_priority_res;
    logic [15:0] o_source_address;
    logic [15:0] o_target_address;
    logic        o_target_is_group;
    logic        o_is_broadcast;
    logic [2:0]  o_routing_count;
    logic [4:0]  o_payload_bytes;
    logic [4:0]  o_service;
    logic [1:0]  o_transport_type;
    logic [3:0]  o_sequence_number;

    t_knx_frame_tracker frame_tracker = new();
    logic [7:0]         frame_buf [23];
    int unsigned        live_words;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;

    knx_telegram_checker_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rx_byte         (i_rx_byte),
        .i_frame_start     (i_frame_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_checksum_ok     (o_checksum_ok),
        .o_repeated        (o_repeated),
        .o_priority_res    (o_priority_res),
        .o_source_address  (o_source_address),
        .o_target_address  (o_target_address),
        .o_target_is_group (o_target_is_group),
        .o_is_broadcast    (o_is_broadcast),
        .o_routing_count   (o_routing_count),
        .o_payload_bytes   (o_payload_bytes),
        .o_service         (o_service),
        .o_transport_type  (o_transport_type),
        .o_sequence_number (o_sequence_number)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("knx_telegram_checker_unit regression: fail");
        $finish;
    end

    // offer one word, idling at random first, and hold it until taken
    task automatic send_word(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        frame_tracker.note_word(b, start);
    endtask

    // send the first n_send words of an n-word telegram, fixing the checksum if asked
    task automatic send_frame(input int n, input int n_send, input bit good_sum);
        logic [7:0] acc;
        acc = XOR_SEED;
        for (int i = 0; i < n - 1; i++) acc ^= frame_buf[i];
        if (good_sum) frame_buf[n-1] = acc;
        for (int i = 0; i < n_send; i++) begin
            send_word(frame_buf[i], i == 0);
            live_words++;
        end
    endtask

    // random telegram aimed at a chosen application service
    task automatic build_telegram(output int n);
        int         r;
        int         len_code;
        logic [4:0] svc;
        logic [3:0] c4;
        logic [5:0] c6;
        r = $urandom_range(99);
        len_code = (r < 70) ? $urandom_range(3) : (r < 85) ? 15 : $urandom_range(15);
        svc = 5'($urandom_range(SVC_RESTART));
        foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
        frame_buf[5][3:0] = 4'(len_code);
        // group target at address zero
        if ($urandom_range(7) == 0) begin
            frame_buf[3]    = 8'd0;
            frame_buf[4]    = 8'd0;
            frame_buf[5][7] = 1'b1;
        end
        c4 = 4'($urandom);
        c6 = 6'($urandom);
        case (svc)
            SVC_GROUP_READ:  c4 = APCI4_GROUP_READ;
            SVC_GROUP_RESP:  c4 = APCI4_GROUP_RESP;
            SVC_GROUP_WRITE: c4 = APCI4_GROUP_WRITE;
            SVC_PHYS_WRITE:  begin c4 = APCI4_PHYS_WRITE; c6 = 6'd0; end
            SVC_PHYS_READ:   begin c4 = APCI4_PHYS_READ;  c6 = 6'd0; end
            SVC_PHYS_RESP:   begin c4 = APCI4_PHYS_RESP;  c6 = 6'd0; end
            SVC_PROP_READ:   begin c4 = APCI4_EXTENDED;   c6 = APCI6_PROP_READ; end
            SVC_PROP_RESP:   begin c4 = APCI4_EXTENDED;   c6 = APCI6_PROP_RESP; end
            SVC_PROP_WRITE:  begin c4 = APCI4_EXTENDED;   c6 = APCI6_PROP_WRITE; end
            SVC_AUTH_REQ:    begin c4 = APCI4_EXTENDED;   c6 = APCI6_AUTH_REQ; end
            SVC_AUTH_RESP:   begin c4 = APCI4_EXTENDED;   c6 = APCI6_AUTH_RESP; end
            SVC_MEM_READ:    begin c4 = APCI4_MEM_READ;   c6[5:4] = 2'b00; end
            SVC_MEM_RESP:    begin c4 = APCI4_MEM_RESP;   c6[5:4] = 2'b00; end
            SVC_MEM_WRITE:   begin c4 = APCI4_MEM_WRITE;  c6[5:4] = 2'b00; end
            SVC_DESC_READ:   begin c4 = APCI4_DESC_READ;  c6 = 6'd0; end
            SVC_DESC_RESP:   begin c4 = APCI4_DESC_RESP;  c6 = 6'd0; end
            SVC_RESTART:     begin c4 = APCI4_RESTART;    c6 = 6'd0; end
            default:         ;
        endcase
        // now and then spoil the low code bits
        if ($urandom_range(9) == 0) c6 = 6'($urandom);
        frame_buf[6][1:0] = c4[3:2];
        frame_buf[7]      = {c4[1:0], c6};
        n = HEADER_BYTES + len_code + 2;
    endtask

    // result side: take decodes and stall at random
    initial begin
        t_telegram seen;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen.checksum_ok     = o_checksum_ok;
                seen.repeated        = o_repeated;
                seen.priority_res    = o_priority_res;
                seen.source_address  = o_source_address;
                seen.target_address  = o_target_address;
                seen.target_is_group = o_target_is_group;
                seen.is_broadcast    = o_is_broadcast;
                seen.routing_count   = o_routing_count;
                seen.payload_bytes   = o_payload_bytes;
                seen.service         = o_service;
                seen.transport_type  = o_transport_type;
                seen.sequence_number = o_sequence_number;
                frame_tracker.check_result(seen);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // main sequence
    initial begin
        int n;
        int r;
        int guard;
        int unsigned target;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_rx_byte     <= 8'd0;
        i_frame_start <= 1'b0;
        live_words     = 0;
        send_idle_pct  = 11;
        recv_idle_pct  = 49;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray word before any frame is open
        send_word(8'h5A, 1'b0);
        // frame cut short and restarted by the next start flag
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'h00;
        frame_buf[2] = 8'hFF;
        send_frame(3, 3, 1'b0);
        // all-ones header, length one: checksum word is decoded as header byte 7
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        frame_buf[5] = 8'hF0;
        send_frame(8, 8, 1'b1);
        // word after the checksum is ignored
        send_word(8'h33, 1'b0);
        // all-zero broadcast, length one, wrong checksum
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        frame_buf[5] = 8'h80;
        send_frame(8, 8, 1'b0);

        // random telegrams over three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 11; recv_idle_pct = 49; end
                1:       begin send_idle_pct = 49; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            target = 20 + (phase + 1) * 460;
            while (live_words < target) begin
                r = $urandom_range(99);
                build_telegram(n);
                if (r < 80) begin
                    send_frame(n, n, $urandom_range(9) != 0);
                    if ($urandom_range(4) == 0)
                        repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
                end else if (r < 92) begin
                    send_frame(n, $urandom_range(1, n - 1), 1'b1);
                end else begin
                    repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
                end
            end
        end
        i_in_valid <= 1'b0;

        // drain, then let the output register settle
        guard = 0;
        while (frame_tracker.owed_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (frame_tracker.owed_q.size() != 0)
            frame_tracker.flag($sformatf("%0d decodes never arrived",
                                         frame_tracker.owed_q.size()));

        if (frame_tracker.failures == 0)
            $display("knx_telegram_checker_unit regression: pass");
        else
            $display("knx_telegram_checker_unit regression: fail");
        $finish;
    end

endmodule
